### hdl/moq_pkg.sv
package moq_pkg;

  // Default queue depth and fixed sizes of the tag space and data memory
  localparam int QueueDepthDef = 16;
  localparam int RobDepth      = 64;
  localparam int MemWords      = 1024;

  localparam int TAG_W  = $clog2(RobDepth);
  localparam int ADDR_W = $clog2(MemWords);
  localparam int DATA_W = 64;
  localparam int FUNC_W = 3;
  localparam int CAP_W  = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Function codes carried by an input transaction
  localparam logic [FUNC_W-1:0] FN_ADD     = 3'd0;
  localparam logic [FUNC_W-1:0] FN_UPDATE  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_RELEASE = 3'd2;
  localparam logic [FUNC_W-1:0] FN_RETIRE  = 3'd3;
  localparam logic [FUNC_W-1:0] FN_FLUSH   = 3'd4;

  // Operation broadcast to every cell of the chain
  typedef enum logic [2:0] {
    CELL_IDLE,
    CELL_ADD,
    CELL_UPDATE,
    CELL_RELEASE,
    CELL_SHIFT,
    CELL_FLUSH,
    CELL_COMPACT
  } moq_cell_op_t;

  // One queue entry as held by a cell
  typedef struct packed {
    logic              valid;
    logic [TAG_W-1:0]  tag;
    logic              load;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
    logic              addr_known;
    logic              data_known;
    logic              retirable;
  } moq_entry_t;

  // Command bus shared by all cells
  typedef struct packed {
    moq_cell_op_t      op;
    logic [TAG_W-1:0]  tag;
    logic              load;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
    logic [TAG_W-1:0]  flush_lo;
    logic [TAG_W-1:0]  flush_hi;
  } moq_cmd_t;

endpackage

### hdl/moq_ifs.sv
interface moq_in_if;
  logic                               valid;
  logic                               ready;
  logic        [moq_pkg::FUNC_W-1:0]  func;
  logic        [moq_pkg::TAG_W-1:0]   rob_tag;
  logic                               is_load;
  logic        [moq_pkg::ADDR_W-1:0]  address;
  logic signed [moq_pkg::DATA_W-1:0]  store_value;
  logic        [moq_pkg::TAG_W-1:0]   flush_start;
  logic        [moq_pkg::TAG_W-1:0]   flush_end;

  modport source (
    output valid, func, rob_tag, is_load, address, store_value, flush_start, flush_end,
    input  ready
  );
  modport sink (
    input  valid, func, rob_tag, is_load, address, store_value, flush_start, flush_end,
    output ready
  );
endinterface

interface moq_out_if;
  logic                               valid;
  logic                               ready;
  logic                               ready_res;
  logic                               retired;
  logic        [moq_pkg::TAG_W-1:0]   retired_tag;
  logic signed [moq_pkg::DATA_W-1:0]  retired_value;

  modport source (
    output valid, ready_res, retired, retired_tag, retired_value,
    input  ready
  );
  modport sink (
    input  valid, ready_res, retired, retired_tag, retired_value,
    output ready
  );
endinterface

### hdl/moq_cell.sv
module moq_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  moq_pkg::moq_cmd_t   cmd,
  input  logic                lower_valid,
  input  logic                gap_in,
  input  moq_pkg::moq_entry_t upper,
  output moq_pkg::moq_entry_t entry
);
  import moq_pkg::*;

  moq_entry_t entry_r;
  moq_entry_t entry_nxt;
  logic       hit;
  logic       in_range;

  // Match the broadcast tag and the inclusive, possibly wrapping, flush range
  always_comb begin
    hit = entry_r.valid && (entry_r.tag == cmd.tag);
    if (cmd.flush_lo <= cmd.flush_hi) begin
      in_range = (entry_r.tag >= cmd.flush_lo) && (entry_r.tag <= cmd.flush_hi);
    end else begin
      in_range = (entry_r.tag <= cmd.flush_hi) || (entry_r.tag >= cmd.flush_lo);
    end
  end

  // Apply the broadcast operation to this cell
  always_comb begin
    entry_nxt = entry_r;
    case (cmd.op)
      CELL_ADD: begin
        // only the first free cell takes the new entry
        if (!entry_r.valid && lower_valid) begin
          entry_nxt.valid      = 1'b1;
          entry_nxt.tag        = cmd.tag;
          entry_nxt.load       = cmd.load;
          entry_nxt.addr_known = 1'b0;
          entry_nxt.data_known = 1'b0;
          entry_nxt.retirable  = 1'b0;
        end
      end
      CELL_UPDATE: begin
        if (hit) begin
          entry_nxt.addr       = cmd.addr;
          entry_nxt.data       = cmd.data;
          entry_nxt.addr_known = 1'b1;
          entry_nxt.data_known = 1'b1;
          entry_nxt.retirable  = entry_r.retirable | entry_r.load;
        end
      end
      CELL_RELEASE: begin
        if (hit) begin
          entry_nxt.retirable = 1'b1;
        end
      end
      CELL_SHIFT: begin
        entry_nxt = upper;
      end
      CELL_FLUSH: begin
        if (entry_r.valid && in_range) begin
          entry_nxt.valid = 1'b0;
        end
      end
      CELL_COMPACT: begin
        // close the lowest hole: everything from it upwards moves down by one
        if (gap_in || !entry_r.valid) begin
          entry_nxt = upper;
        end
      end
      default: ;
    endcase
  end

  // Hold the entry; clear only its control bits at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r.valid      <= 1'b0;
      entry_r.addr_known <= 1'b0;
      entry_r.data_known <= 1'b0;
      entry_r.retirable  <= 1'b0;
    end else begin
      entry_r <= entry_nxt;
    end
  end

  assign entry = entry_r;

endmodule

### hdl/memory_order_queue.sv
// In-order queue of memory operations with an internal 1024-word data memory.
// in_ch carries one transaction per operation (add, update, release, retire,
// flush); out_ch returns exactly one result transaction for each of them,
// in order. cfg_we/cfg_wdata write the capacity register at any time the
// block is idle.
// Sequence: add, update, release and retire act on the cells at the accepting
// edge and unused codes leave them as they are; the sequencer then enters its
// completion step, and the output register loads from it once it is free. A
// flush first passes through compaction, which closes one hole below the last
// kept entry per step until the chain is seen packed. in_ch.ready is high only
// while the sequencer is idle, so the block takes no new transaction until
// the previous one has been handed to the output register.
// Reset: entries are dropped, capacity returns to 16 and the data memory is
// swept to zero, one word per cycle, over all 1024 words; in_ch.ready stays low
// during the sweep while configuration writes are still taken.
// A stalled receiver holds the result in the output register; the next
// transaction is still accepted and waits for the register to free up.
module memory_order_queue #(
  parameter int QUEUE_DEPTH = moq_pkg::QueueDepthDef
) (
  input  logic                       clk,
  input  logic                       rst_n,
  moq_in_if.sink                     in_ch,
  moq_out_if.source                  out_ch,
  input  logic                       cfg_we,
  input  logic [moq_pkg::CAP_W-1:0]  cfg_wdata
);
  import moq_pkg::*;

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [3:0] {
    ST_CLEAR   = 4'b0001,
    ST_IDLE    = 4'b0010,
    ST_COMPACT = 4'b0100,
    ST_DONE    = 4'b1000
  } state_t;

  state_t                  state_r, state_nxt;
  logic [CAP_W-1:0]        capacity_r;
  logic [ADDR_W-1:0]       clr_addr_r;
  logic [DATA_W-1:0]       mem [MemWords];
  logic [DATA_W-1:0]       mem_rdata_r;
  logic                    mem_we;
  logic [ADDR_W-1:0]       mem_waddr;
  logic [DATA_W-1:0]       mem_wdata;

  moq_entry_t              entries [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]  valid_vec;
  logic [QUEUE_DEPTH-1:0]  gap;
  moq_cmd_t                cmd;

  logic                    accept;
  logic                    head_ok;
  logic [CNT_W-1:0]        cap_eff;
  logic [CNT_W-1:0]        cap_last;
  logic                    full;
  logic                    compact_done;
  logic                    out_load;

  logic                    pend_retired_r;
  logic [TAG_W-1:0]        pend_tag_r;
  logic                    pend_load_r;

  logic                    out_valid_r;
  logic                    out_ready_res_r;
  logic                    out_retired_r;
  logic [TAG_W-1:0]        out_tag_r;
  logic [DATA_W-1:0]       out_value_r;

  // Chain of cells: each takes from its upper neighbour on shift or compaction
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    moq_entry_t upper;
    logic       lower_valid;

    if (i == QUEUE_DEPTH - 1) begin : g_top
      assign upper = '0;
    end else begin : g_mid
      assign upper = entries[i+1];
    end

    if (i == 0) begin : g_head
      assign lower_valid = 1'b1;
    end else begin : g_body
      assign lower_valid = entries[i-1].valid;
    end

    moq_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cmd         (cmd),
      .lower_valid (lower_valid),
      .gap_in      (gap[i]),
      .upper       (upper),
      .entry       (entries[i])
    );

    assign valid_vec[i] = entries[i].valid;
  end

  // Propagate "a hole lies below" up the chain
  always_comb begin
    gap[0] = 1'b0;
    for (int i = 1; i < QUEUE_DEPTH; i++) begin
      gap[i] = gap[i-1] | ~valid_vec[i-1];
    end
  end

  assign compact_done = ~|(gap & valid_vec);

  // Effective capacity and the full flag of a compact queue
  always_comb begin
    if (int'(capacity_r) > QUEUE_DEPTH) begin
      cap_eff = CNT_W'(QUEUE_DEPTH);
    end else begin
      cap_eff = CNT_W'(capacity_r);
    end
    cap_last = cap_eff - 1'b1;
    full     = (cap_eff == '0) || valid_vec[cap_last[IDX_W-1:0]];
  end

  assign accept  = in_ch.valid && in_ch.ready;
  assign head_ok = entries[0].valid && entries[0].retirable &&
                   entries[0].addr_known && entries[0].data_known;

  // Decode the transaction into the cell command
  always_comb begin
    cmd.op       = CELL_IDLE;
    cmd.tag      = in_ch.rob_tag;
    cmd.load     = in_ch.is_load;
    cmd.addr     = in_ch.address;
    cmd.data     = in_ch.store_value;
    cmd.flush_lo = in_ch.flush_start;
    cmd.flush_hi = in_ch.flush_end;
    if (state_r == ST_COMPACT) begin
      cmd.op = CELL_COMPACT;
    end else if (accept) begin
      unique case (in_ch.func)
        FN_ADD:     cmd.op = full ? CELL_IDLE : CELL_ADD;
        FN_UPDATE:  cmd.op = CELL_UPDATE;
        FN_RELEASE: cmd.op = CELL_RELEASE;
        FN_RETIRE:  cmd.op = head_ok ? CELL_SHIFT : CELL_IDLE;
        FN_FLUSH:   cmd.op = CELL_FLUSH;
        default:    cmd.op = CELL_IDLE;
      endcase
    end
  end

  // Memory write: zero sweep after reset, or a retiring store
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = entries[0].addr;
    mem_wdata = entries[0].data;
    if (state_r == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_r;
      mem_wdata = '0;
    end else if (accept && (in_ch.func == FN_RETIRE) && head_ok && !entries[0].load) begin
      mem_we = 1'b1;
    end
  end

  // Data memory; capture the head word when a transaction is taken
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (accept) begin
      mem_rdata_r <= mem[entries[0].addr];
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_addr_r == ADDR_W'(MemWords - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_nxt = (in_ch.func == FN_FLUSH) ? ST_COMPACT : ST_DONE;
        end
      end
      ST_COMPACT: begin
        if (compact_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_ch.ready = (state_r == ST_IDLE);
  assign out_load    = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      capacity_r  <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
      if (cfg_we) begin
        capacity_r <= cfg_wdata;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Hold the retire outcome until the result is formed
  always_ff @(posedge clk) begin
    if (accept) begin
      pend_retired_r <= (in_ch.func == FN_RETIRE) && head_ok;
      pend_tag_r     <= entries[0].tag;
      pend_load_r    <= entries[0].load;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ready_res_r <= !full;
      out_retired_r   <= pend_retired_r;
      out_tag_r       <= pend_retired_r ? pend_tag_r : '0;
      out_value_r     <= (pend_retired_r && pend_load_r) ? mem_rdata_r : '0;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.ready_res     = out_ready_res_r;
  assign out_ch.retired       = out_retired_r;
  assign out_ch.retired_tag   = out_tag_r;
  assign out_ch.retired_value = out_value_r;

  // Entries stay packed at the head whenever a transaction can be taken
  a_packed: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> ((valid_vec & (valid_vec + 1'b1)) == '0))
    else $error("queue entries not contiguous while idle");

  // A result appears only from the completion step
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_DONE))
    else $error("result raised outside completion step");

  // A result that did not retire carries zero tag and value
  a_no_retire_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_retired_r) |-> ((out_tag_r == '0) && (out_value_r == '0)))
    else $error("non-retiring result carries tag or value");

  // Compaction never touches the data memory
  a_compact_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COMPACT) |-> !mem_we)
    else $error("memory written during compaction");

endmodule

### tb/memory_order_queue_checker.sv
module memory_order_queue_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  moq_in_if                         in_mon,
  moq_out_if                        out_mon,
  input  logic                      cfg_we,
  input  logic [moq_pkg::CAP_W-1:0] cfg_wdata,
  output int                        fail_count,
  output int                        pending
);

  import moq_pkg::*;

  localparam int Slots = QueueDepthDef;

  // One queue slot as the prediction sees it
  typedef struct {
    logic [TAG_W-1:0]  tag;
    logic              load;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
    logic              addr_known;
    logic              data_known;
    logic              retirable;
  } lsq_slot_t;

  // One result transaction
  typedef struct {
    logic              ready_res;
    logic              retired;
    logic [TAG_W-1:0]  retired_tag;
    logic [DATA_W-1:0] retired_value;
  } retire_result_t;

  lsq_slot_t         lsq_slots [Slots];
  int unsigned       lsq_count;
  logic [CAP_W-1:0]  lsq_capacity;
  logic [DATA_W-1:0] mem_words [MemWords];
  retire_result_t    result_fifo [$];

  function automatic int unsigned usable_slots();
    return (lsq_capacity > Slots) ? Slots : int'(lsq_capacity);
  endfunction

  function automatic logic tag_flushed(input logic [TAG_W-1:0] t,
                                       input logic [TAG_W-1:0] lo,
                                       input logic [TAG_W-1:0] hi);
    if (lo <= hi) return (t >= lo) && (t <= hi);
    return (t <= hi) || (t >= lo);
  endfunction

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    $display("MISMATCH %s: got 0x%0h, expected 0x%0h (t=%0t)", what, got, want, $time);
    fail_count++;
  endtask

  // Apply one operation to the queue copy and work out its result
  task automatic apply_operation(input logic [FUNC_W-1:0] func,
                                 input logic [TAG_W-1:0] tag,
                                 input logic is_load,
                                 input logic [ADDR_W-1:0] addr,
                                 input logic [DATA_W-1:0] value,
                                 input logic [TAG_W-1:0] fs,
                                 input logic [TAG_W-1:0] fe,
                                 output retire_result_t res);
    int unsigned keep;
    lsq_slot_t   head;
    res = '{1'b0, 1'b0, '0, '0};
    case (func)
      FN_ADD: begin
        if (lsq_count < usable_slots()) begin
          lsq_slots[lsq_count] = '{tag, is_load, '0, '0, 1'b0, 1'b0, 1'b0};
          lsq_count++;
        end
      end
      FN_UPDATE: begin
        for (int i = 0; i < lsq_count; i++) begin
          if (lsq_slots[i].tag == tag) begin
            lsq_slots[i].addr       = addr;
            lsq_slots[i].data       = value;
            lsq_slots[i].addr_known = 1'b1;
            lsq_slots[i].data_known = 1'b1;
            if (lsq_slots[i].load) lsq_slots[i].retirable = 1'b1;
          end
        end
      end
      FN_RELEASE: begin
        for (int i = 0; i < lsq_count; i++)
          if (lsq_slots[i].tag == tag) lsq_slots[i].retirable = 1'b1;
      end
      FN_RETIRE: begin
        if (lsq_count > 0) begin
          head = lsq_slots[0];
          if (head.retirable && head.addr_known && head.data_known) begin
            if (head.load) res.retired_value = mem_words[head.addr];
            else           mem_words[head.addr] = head.data;
            res.retired     = 1'b1;
            res.retired_tag = head.tag;
            for (int i = 1; i < lsq_count; i++) lsq_slots[i-1] = lsq_slots[i];
            lsq_count--;
          end
        end
      end
      FN_FLUSH: begin
        keep = 0;
        for (int i = 0; i < lsq_count; i++) begin
          if (!tag_flushed(lsq_slots[i].tag, fs, fe)) begin
            lsq_slots[keep] = lsq_slots[i];
            keep++;
          end
        end
        lsq_count = keep;
      end
      default: ;
    endcase
    res.ready_res = (lsq_count < usable_slots());
  endtask

  // Watch both channels and the register port on every rising edge
  always @(posedge clk) begin
    retire_result_t seen;
    retire_result_t want;
    retire_result_t got;
    if (!rst_n) begin
      lsq_count    = 0;
      lsq_capacity = CAP_RESET;
      foreach (mem_words[i]) mem_words[i] = '0;
      result_fifo.delete();
    end else begin
      // Check the result transaction against the oldest expectation first
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.ready_res, out_mon.retired, out_mon.retired_tag,
                out_mon.retired_value};
        if (result_fifo.size() == 0) begin
          report_mismatch("result with nothing outstanding", got.retired_value, '0);
        end else begin
          want = result_fifo.pop_front();
          if (got.ready_res !== want.ready_res)
            report_mismatch("ready_res", got.ready_res, want.ready_res);
          if (got.retired !== want.retired)
            report_mismatch("retired", got.retired, want.retired);
          if (got.retired_tag !== want.retired_tag)
            report_mismatch("retired_tag", got.retired_tag, want.retired_tag);
          if (got.retired_value !== want.retired_value)
            report_mismatch("retired_value", got.retired_value, want.retired_value);
        end
      end
      if (cfg_we) lsq_capacity = cfg_wdata;
      // Predict the accepted input transaction
      if (in_mon.valid && in_mon.ready) begin
        apply_operation(in_mon.func, in_mon.rob_tag, in_mon.is_load, in_mon.address,
                        in_mon.store_value, in_mon.flush_start, in_mon.flush_end, seen);
        result_fifo = {result_fifo, seen};
      end
    end
    pending = result_fifo.size();
  end

endmodule

### tb/memory_order_queue_tb.sv
module memory_order_queue_tb;

  import moq_pkg::*;

  localparam logic [FUNC_W-1:0] FN_SPARE_LO  = 3'd5;
  localparam logic [FUNC_W-1:0] FN_SPARE_MID = 3'd6;
  localparam logic [FUNC_W-1:0] FN_SPARE_HI  = 3'd7;
  localparam logic [DATA_W-1:0] DATA_MIN    = 64'h8000_0000_0000_0000;
  localparam logic [DATA_W-1:0] DATA_MAX    = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [DATA_W-1:0] DATA_ONES   = '1;
  localparam int HoldCycles  = 200;
  localparam int TailCycles  = 40;
  localparam int PhaseItems  = 210;
  localparam int EmptyItems  = 80;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we = 1'b0;
  logic [CAP_W-1:0] cfg_wdata = '0;
  int               fail_count;
  int               pending;

  // Receiver behaviour, set by the stimulus process on rising edges
  int               rx_mode = 0;
  int               hold_reqs = 0;
  int               hold_seen = 0;
  int               hold_left = 0;
  int               rx_phase = 0;

  // Stimulus bookkeeping
  logic [TAG_W-1:0] live_tags [$];
  logic [TAG_W-1:0] next_tag = '0;
  int unsigned      live_limit = 16;
  bit               gapless = 1'b0;
  int               burst_left = 0;

  moq_in_if  in_ch ();
  moq_out_if out_ch ();

  memory_order_queue i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  memory_order_queue_checker i_result_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #5 clk = ~clk;

  // Give up after a generous fixed time
  initial begin
    #5_000_000;
    $display("memory_order_queue test failed");
    $finish;
  end

  // Receiver: stall on its own pattern, or hold off for a long stretch on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_seen != hold_reqs) begin
        hold_seen = hold_reqs;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready = 1'b0;
      end else begin
        rx_phase++;
        case (rx_mode)
          0:       out_ch.ready = 1'b1;
          1:       out_ch.ready = ($urandom_range(0, 3) != 0);
          2:       out_ch.ready = ((rx_phase % 5) < 3);
          default: out_ch.ready = ($urandom_range(0, 9) < 3);
        endcase
      end
    end
  end

  // Offer one transaction and hold it until it is taken
  task automatic send_op(input logic [FUNC_W-1:0] func, input logic [TAG_W-1:0] tag,
                         input logic ld, input logic [ADDR_W-1:0] addr,
                         input logic [DATA_W-1:0] value, input logic [TAG_W-1:0] fs,
                         input logic [TAG_W-1:0] fe);
    @(negedge clk);
    in_ch.valid       = 1'b1;
    in_ch.func        = func;
    in_ch.rob_tag     = tag;
    in_ch.is_load     = ld;
    in_ch.address     = addr;
    in_ch.store_value = value;
    in_ch.flush_start = fs;
    in_ch.flush_end   = fe;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic idle_cycles(input int n);
    repeat (n) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
    end
  endtask

  // Stop offering and wait until every result has come back
  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = cap;
    @(negedge clk);
    cfg_we    = 1'b0;
    live_limit = (cap == 0) ? 1 : ((cap > QueueDepthDef) ? QueueDepthDef : cap);
    live_tags.delete();
  endtask

  function automatic logic [DATA_W-1:0] pick_data();
    case ($urandom_range(0, 19))
      0:       return DATA_MIN;
      1:       return DATA_MAX;
      2:       return '0;
      3:       return DATA_ONES;
      4:       return DATA_W'($urandom_range(0, 255));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [ADDR_W-1:0] pick_addr();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return ADDR_W'($urandom);
      default: return ADDR_W'($urandom_range(0, 15));
    endcase
  endfunction

  // Pick a tag near the head of the queue, with some strays
  function automatic logic [TAG_W-1:0] pick_live_tag();
    int unsigned span;
    if (live_tags.size() == 0 || $urandom_range(0, 9) == 0) return TAG_W'($urandom);
    span = (live_tags.size() < 4) ? live_tags.size() : 4;
    return live_tags[$urandom_range(0, span - 1)];
  endfunction

  // Build one random operation, mostly well-formed, and send it
  task automatic issue_random_op();
    int               r;
    logic [TAG_W-1:0] tag;
    logic [TAG_W-1:0] fs;
    logic [TAG_W-1:0] fe;
    r = $urandom_range(0, 99);
    if (r < 28) begin
      if ($urandom_range(0, 9) == 0) tag = pick_live_tag();
      else begin
        tag = next_tag;
        next_tag++;
      end
      if (live_tags.size() < live_limit) live_tags = {live_tags, tag};
      send_op(FN_ADD, tag, 1'($urandom_range(0, 1)), ADDR_W'($urandom),
              {$urandom, $urandom}, TAG_W'($urandom), TAG_W'($urandom));
    end else if (r < 52) begin
      send_op(FN_UPDATE, pick_live_tag(), 1'($urandom_range(0, 1)), pick_addr(),
              pick_data(), TAG_W'($urandom), TAG_W'($urandom));
    end else if (r < 67) begin
      send_op(FN_RELEASE, pick_live_tag(), 1'($urandom_range(0, 1)), ADDR_W'($urandom),
              {$urandom, $urandom}, TAG_W'($urandom), TAG_W'($urandom));
    end else if (r < 89) begin
      if (live_tags.size() != 0 && $urandom_range(0, 1) == 1) void'(live_tags.pop_front());
      send_op(FN_RETIRE, TAG_W'($urandom), 1'($urandom_range(0, 1)), ADDR_W'($urandom),
              {$urandom, $urandom}, TAG_W'($urandom), TAG_W'($urandom));
    end else if (r < 95) begin
      // Narrow range around a queued tag, or a wide or wrapping one
      case ($urandom_range(0, 3))
        0, 1: begin
          fs = pick_live_tag();
          fe = fs + TAG_W'($urandom_range(0, 3));
        end
        2: begin
          fs = TAG_W'($urandom_range(32, 63));
          fe = TAG_W'($urandom_range(0, 31));
        end
        default: begin
          fs = TAG_W'($urandom);
          fe = TAG_W'($urandom);
        end
      endcase
      for (int i = live_tags.size() - 1; i >= 0; i--) begin
        if ((fs <= fe) ? (live_tags[i] >= fs && live_tags[i] <= fe)
                       : (live_tags[i] <= fe || live_tags[i] >= fs))
          live_tags.delete(i);
      end
      send_op(FN_FLUSH, TAG_W'($urandom), 1'($urandom_range(0, 1)), ADDR_W'($urandom),
              {$urandom, $urandom}, fs, fe);
    end else if (r < 98) begin
      send_op(FUNC_W'($urandom_range(FN_SPARE_LO, FN_SPARE_HI)), TAG_W'($urandom),
              1'($urandom_range(0, 1)), ADDR_W'($urandom), {$urandom, $urandom},
              TAG_W'($urandom), TAG_W'($urandom));
    end else begin
      send_op(FUNC_W'($urandom), TAG_W'($urandom), 1'($urandom_range(0, 1)),
              ADDR_W'($urandom), {$urandom, $urandom}, TAG_W'($urandom),
              TAG_W'($urandom));
    end
  endtask

  // Insert sender gaps between bursts of random length
  task automatic pace_sender();
    if (burst_left == 0) begin
      if (!gapless) idle_cycles($urandom_range(1, 6));
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
  endtask

  initial begin
    logic [CAP_W-1:0] cap_plan [10];
    int               n_items;
    cap_plan = '{5'd1, 5'd31, 5'd0, 5'd4, 5'd17, 5'd2, 5'd16, 5'd9, 5'd31, 5'd16};

    in_ch.valid       = 1'b0;
    in_ch.func        = FN_ADD;
    in_ch.rob_tag     = '0;
    in_ch.is_load     = 1'b0;
    in_ch.address     = '0;
    in_ch.store_value = '0;
    in_ch.flush_start = '0;
    in_ch.flush_end   = '0;

    // Start in reset, then release it for good
    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    write_capacity(CAP_RESET);

    // Directed: empty retire, extremes, release order, duplicates, wrapping flush
    send_op(FN_RETIRE,  6'd0,  1'b0, 10'd0,    '0,        6'd0,  6'd0);
    send_op(FN_ADD,     6'd0,  1'b0, 10'd0,    '0,        6'd0,  6'd0);
    send_op(FN_ADD,     6'd63, 1'b1, 10'd0,    '0,        6'd0,  6'd0);
    send_op(FN_UPDATE,  6'd63, 1'b0, 10'd1023, DATA_MAX,  6'd0,  6'd0);
    send_op(FN_RETIRE,  6'd0,  1'b0, 10'd0,    '0,        6'd0,  6'd0);
    send_op(FN_UPDATE,  6'd0,  1'b0, 10'd1023, DATA_MIN,  6'd0,  6'd0);
    send_op(FN_RELEASE, 6'd0,  1'b0, 10'd0,    '0,        6'd0,  6'd0);
    send_op(FN_RETIRE,  6'd0,  1'b0, 10'd0,    '0,        6'd0,  6'd0);
    send_op(FN_RETIRE,  6'd0,  1'b0, 10'd0,    '0,        6'd0,  6'd0);
    send_op(FN_UPDATE,  6'd5,  1'b1, 10'd3,    DATA_ONES, 6'd0,  6'd0);
    send_op(FN_RELEASE, 6'd5,  1'b1, 10'd3,    '0,        6'd0,  6'd0);
    send_op(FN_SPARE_LO, 6'd63, 1'b1, 10'd1023, DATA_ONES, 6'd63, 6'd63);
    send_op(FN_SPARE_MID, 6'd63, 1'b1, 10'd1023, DATA_ONES, 6'd63, 6'd63);
    send_op(FN_SPARE_HI, 6'd63, 1'b1, 10'd1023, DATA_ONES, 6'd63, 6'd63);
    send_op(FN_ADD,     6'd7,  1'b0, 10'd0,    '0,        6'd0,  6'd0);
    send_op(FN_ADD,     6'd7,  1'b1, 10'd0,    '0,        6'd0,  6'd0);
    send_op(FN_UPDATE,  6'd7,  1'b0, 10'd0,    DATA_ONES, 6'd0,  6'd0);
    send_op(FN_RELEASE, 6'd7,  1'b0, 10'd0,    '0,        6'd0,  6'd0);
    send_op(FN_RETIRE,  6'd0,  1'b0, 10'd0,    '0,        6'd0,  6'd0);
    send_op(FN_RETIRE,  6'd0,  1'b0, 10'd0,    '0,        6'd0,  6'd0);
    send_op(FN_ADD,     6'd60, 1'b0, 10'd0,    '0,        6'd0,  6'd0);
    send_op(FN_ADD,     6'd2,  1'b1, 10'd0,    '0,        6'd0,  6'd0);
    send_op(FN_ADD,     6'd30, 1'b0, 10'd0,    '0,        6'd0,  6'd0);
    send_op(FN_FLUSH,   6'd0,  1'b0, 10'd0,    '0,        6'd58, 6'd3);
    send_op(FN_FLUSH,   6'd0,  1'b0, 10'd0,    '0,        6'd0,  6'd63);
    drain();

    // Random phases, each with its own capacity, receiver pattern and pacing
    foreach (cap_plan[p]) begin
      write_capacity(cap_plan[p]);
      @(posedge clk);
      rx_mode    = p % 4;
      gapless    = (p % 3 == 2);
      burst_left = 0;
      n_items    = (cap_plan[p] == 0) ? EmptyItems : PhaseItems;
      // Long receiver hold-off while the sender keeps offering
      if (p == 6) begin
        rx_mode   = 0;
        gapless   = 1'b1;
        hold_reqs = hold_reqs + 1;
      end
      repeat (n_items) begin
        pace_sender();
        issue_random_op();
      end
      drain();
    end

    repeat (TailCycles) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("memory_order_queue test passed");
    end else begin
      $display("memory_order_queue test failed");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/moq_pkg.sv
hdl/moq_ifs.sv
hdl/moq_cell.sv
hdl/memory_order_queue.sv
tb/memory_order_queue_checker.sv
tb/memory_order_queue_tb.sv
